// ----- design/assert_macros.svh -----
// Assertion macros used by the histogram unit. Each use samples on clk and is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dws_pkg.sv -----
`timescale 1ns / 1ps
package dws_pkg;

  localparam int FRAME_DEPTH      = 512;
  localparam int TIME_BINS        = 4096;
  localparam int DEFAULT_FRAME_MS = 8;

  localparam int RING_DEPTH = FRAME_DEPTH + 1;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int HIST_AW    = $clog2(TIME_BINS);

  localparam int FT_W    = 10;
  localparam int IDX_W   = 12;
  localparam int UW_W    = 16;
  localparam int SUM_W   = 20;
  localparam int BIN_W   = 18;
  localparam int W_W     = 17;
  localparam int COUNT_W = 32;
  localparam int FRAC_W  = 16;
  localparam int DIV_CW  = $clog2(W_W);

  localparam logic [W_W-1:0]   ONE_Q16   = W_W'(65536);
  localparam logic [UW_W-1:0]  UW_RESET  = UW_W'(655);
  localparam logic [SUM_W-1:0] SUM_MAX   = '1;
  localparam logic [BIN_W-1:0] BIN_MAX   = '1;
  localparam logic [FT_W-1:0]  FT_DEFAULT = FT_W'(DEFAULT_FRAME_MS);

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

endpackage

// ----- design/dws_div.sv -----
`timescale 1ns / 1ps
module dws_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dws_pkg::COUNT_W-1:0]  divisor,
  output logic                         done,
  output logic [dws_pkg::W_W-1:0]      quotient
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [dws_pkg::DIV_CW-1:0]   cnt_r, cnt_nxt;
  logic [dws_pkg::COUNT_W-1:0]  rem_r, rem_nxt;
  logic [dws_pkg::COUNT_W-1:0]  d_r, d_nxt;
  logic [dws_pkg::W_W-1:0]      q_r, q_nxt;
  logic [dws_pkg::COUNT_W:0]    shifted;
  logic [dws_pkg::COUNT_W:0]    diff;
  logic                         ge;

  assign shifted = {rem_r, dws_pkg::ONE_Q16[cnt_r]};
  assign ge      = shifted >= {1'b0, d_r};
  assign diff    = shifted - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = dws_pkg::DIV_CW'(dws_pkg::W_W - 1);
      rem_nxt  = '0;
      d_nxt    = divisor;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[dws_pkg::COUNT_W-1:0] : shifted[dws_pkg::COUNT_W-1:0];
      q_nxt   = {q_r[dws_pkg::W_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- design/dws_ring.sv -----
`timescale 1ns / 1ps
module dws_ring (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [dws_pkg::FT_W-1:0]     push_time,
  input  logic [dws_pkg::RING_AW-1:0]  rd_pos,
  output logic [dws_pkg::FT_W-1:0]     rd_time
);

  logic [dws_pkg::FT_W-1:0]    ring_mem [dws_pkg::RING_DEPTH];
  logic [dws_pkg::RING_AW-1:0] head_r, head_nxt;
  logic [dws_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  logic [dws_pkg::RING_AW:0]   addr_ext;
  logic [dws_pkg::RING_AW-1:0] rd_addr;
  logic [dws_pkg::FT_W-1:0]    rd_q_r;
  logic                        hit_r;

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (push) begin
      head_nxt = (head_r == dws_pkg::RING_AW'(dws_pkg::RING_DEPTH - 1)) ? '0 : head_r + 1'b1;
      if (fill_r != dws_pkg::FILL_W'(dws_pkg::RING_DEPTH)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  // walk back from the newest entry
  always_comb begin
    if (rd_pos <= head_r) begin
      addr_ext = {1'b0, head_r} - {1'b0, rd_pos};
    end else begin
      addr_ext = {1'b0, head_r} + (dws_pkg::RING_AW + 1)'(dws_pkg::RING_DEPTH)
                 - {1'b0, rd_pos};
    end
    rd_addr = addr_ext[dws_pkg::RING_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ring_mem[head_nxt] <= push_time;
    end
    rd_q_r <= ring_mem[rd_addr];
    hit_r  <= dws_pkg::FILL_W'(rd_pos) < fill_r;
  end

  assign rd_time = hit_r ? rd_q_r : dws_pkg::FT_DEFAULT;

endmodule

// ----- design/decaying_window_sum_histogram_unit.sv -----
`timescale 1ns / 1ps
// Read item: the bin is latched into the result register in S_READ and presented from S_DONE.
// Report item: the weight divide, then the decay sweep through the histogram memory port,
// then a walk over the window sums (at most FRAME_DEPTH + 1), each bin read and then incremented.
// One item is in work at a time; a waiting result does not block accept.
// Reset clears control state at once; a read before the first report returns zero and the
// first report zeroes every bin, so the histogram memory needs no clearing pass.
`include "assert_macros.svh"
module decaying_window_sum_histogram_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [dws_pkg::UW_W-1:0]      cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [dws_pkg::FT_W-1:0]      in_frame_time_ms,
  input  logic [dws_pkg::IDX_W-1:0]     in_bin_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dws_pkg::BIN_W-1:0]     out_bin_value,
  output logic [dws_pkg::COUNT_W-1:0]   out_reports_seen
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_DECAY = 8'b0000_1000,
    S_WRD   = 8'b0001_0000,
    S_WSUM  = 8'b0010_0000,
    S_HWR   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  localparam int PROD_W = dws_pkg::BIN_W + dws_pkg::W_W;
  localparam int DEC_W  = dws_pkg::HIST_AW + 1;

  state_t                          state_r, state_nxt;
  logic [dws_pkg::COUNT_W-1:0]     count_r, count_nxt, count_inc;
  logic [dws_pkg::UW_W-1:0]        uw_r;
  logic [dws_pkg::W_W-1:0]         w_r, w_nxt, keep_r, keep_nxt, w_sel;
  logic [dws_pkg::RING_AW-1:0]     pos_r, pos_nxt, ring_rd_pos;
  logic [dws_pkg::SUM_W-1:0]       sum_r, sum_nxt, sum_new, sum_sat;
  logic [dws_pkg::SUM_W:0]         sum_add;
  logic                            sum_beyond;
  logic [DEC_W-1:0]                dec_cnt_r, dec_cnt_nxt;
  logic                            p1_valid_r, p1_valid_nxt, p2_valid_r;
  logic [dws_pkg::HIST_AW-1:0]     p1_addr_r, p1_addr_nxt, p2_addr_r;
  logic [PROD_W-1:0]               mult;
  logic [dws_pkg::BIN_W-1:0]       prod_r, prod_nxt;
  logic [dws_pkg::BIN_W-1:0]       hist_mem [dws_pkg::TIME_BINS];
  logic [dws_pkg::BIN_W-1:0]       rd_data_r;
  logic [dws_pkg::HIST_AW-1:0]     hist_rd_addr, hist_wa;
  logic [dws_pkg::BIN_W-1:0]       hist_wd, bin_sat;
  logic [dws_pkg::BIN_W:0]         bin_add;
  logic                            hist_we, hist_we_inc;
  logic                            rd_ok_r, rd_ok_nxt;
  logic [dws_pkg::BIN_W-1:0]       res_bin_r, res_bin_nxt;
  logic                            out_valid_r, out_valid_nxt, out_load;
  logic [dws_pkg::BIN_W-1:0]       out_bin_value_r;
  logic [dws_pkg::COUNT_W-1:0]     out_reports_seen_r;
  logic                            in_acc, is_report;
  logic                            div_start, div_done;
  logic [dws_pkg::W_W-1:0]         div_q;
  logic [dws_pkg::FT_W-1:0]        ring_time;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign is_report = (in_operation == dws_pkg::OP_REPORT);
  assign div_start = in_acc && is_report;
  assign count_inc = (count_r == '1) ? count_r : count_r + 1'b1;

  dws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (count_inc),
    .done     (div_done),
    .quotient (div_q)
  );

  dws_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (div_start),
    .push_time (in_frame_time_ms),
    .rd_pos    (ring_rd_pos),
    .rd_time   (ring_time)
  );

  assign w_sel = (div_q > dws_pkg::W_W'(uw_r)) ? div_q : dws_pkg::W_W'(uw_r);

  assign sum_add    = {1'b0, sum_r} + (dws_pkg::SUM_W + 1)'(ring_time);
  assign sum_sat    = sum_add[dws_pkg::SUM_W] ? dws_pkg::SUM_MAX : sum_add[dws_pkg::SUM_W-1:0];
  assign sum_new    = (pos_r == '0) ? dws_pkg::SUM_W'(ring_time) : sum_sat;
  assign sum_beyond = 32'(sum_new) >= dws_pkg::TIME_BINS;

  assign bin_add = {1'b0, rd_data_r} + (dws_pkg::BIN_W + 1)'(w_r);
  assign bin_sat = (bin_add > {1'b0, dws_pkg::BIN_MAX}) ? dws_pkg::BIN_MAX
                                                        : bin_add[dws_pkg::BIN_W-1:0];

  assign mult     = PROD_W'(rd_data_r) * PROD_W'(keep_r);
  assign prod_nxt = (keep_r == '0) ? '0
                                   : mult[dws_pkg::BIN_W+dws_pkg::FRAC_W-1:dws_pkg::FRAC_W];

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    w_nxt        = w_r;
    keep_nxt     = keep_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    dec_cnt_nxt  = dec_cnt_r;
    p1_valid_nxt = 1'b0;
    p1_addr_nxt  = p1_addr_r;
    rd_ok_nxt    = rd_ok_r;
    res_bin_nxt  = res_bin_r;
    hist_rd_addr = dws_pkg::HIST_AW'(in_bin_index);
    ring_rd_pos  = pos_r;
    hist_we_inc  = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (is_report) begin
            count_nxt   = count_inc;
            res_bin_nxt = '0;
            dec_cnt_nxt = '0;
            state_nxt   = S_DIV;
          end else begin
            rd_ok_nxt = (count_r != '0) && (32'(in_bin_index) < dws_pkg::TIME_BINS);
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        res_bin_nxt = rd_ok_r ? rd_data_r : '0;
        state_nxt   = S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          w_nxt     = w_sel;
          keep_nxt  = dws_pkg::ONE_Q16 - w_sel;
          state_nxt = S_DECAY;
        end
      end
      S_DECAY: begin
        if (dec_cnt_r < DEC_W'(dws_pkg::TIME_BINS)) begin
          hist_rd_addr = dec_cnt_r[dws_pkg::HIST_AW-1:0];
          p1_valid_nxt = 1'b1;
          p1_addr_nxt  = dec_cnt_r[dws_pkg::HIST_AW-1:0];
          dec_cnt_nxt  = dec_cnt_r + 1'b1;
        end else if (!p1_valid_r && !p2_valid_r) begin
          pos_nxt   = '0;
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        state_nxt = S_WSUM;
      end
      S_WSUM: begin
        sum_nxt = sum_new;
        if (sum_beyond) begin
          state_nxt = S_DONE;
        end else begin
          hist_rd_addr = sum_new[dws_pkg::HIST_AW-1:0];
          state_nxt    = S_HWR;
        end
      end
      S_HWR: begin
        hist_we_inc = 1'b1;
        ring_rd_pos = pos_r + 1'b1;
        if (pos_r == dws_pkg::RING_AW'(dws_pkg::FRAME_DEPTH)) begin
          state_nxt = S_DONE;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_WSUM;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign hist_we = p2_valid_r || hist_we_inc;
  assign hist_wa = p2_valid_r ? p2_addr_r : sum_r[dws_pkg::HIST_AW-1:0];
  assign hist_wd = p2_valid_r ? prod_r : bin_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      uw_r        <= dws_pkg::UW_RESET;
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      dec_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      if (cfg_wr_en) begin
        uw_r <= cfg_wr_data;
      end
      p1_valid_r  <= p1_valid_nxt;
      p2_valid_r  <= p1_valid_r;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      dec_cnt_r   <= dec_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r       <= w_nxt;
    keep_r    <= keep_nxt;
    sum_r     <= sum_nxt;
    p1_addr_r <= p1_addr_nxt;
    p2_addr_r <= p1_addr_r;
    prod_r    <= prod_nxt;
    rd_ok_r   <= rd_ok_nxt;
    res_bin_r <= res_bin_nxt;
    if (out_load) begin
      out_bin_value_r    <= res_bin_r;
      out_reports_seen_r <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    rd_data_r <= hist_mem[hist_rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_bin_value    = out_bin_value_r;
  assign out_reports_seen = out_reports_seen_r;

  `DWS_ASSERT_IMP(a_decay_after_count, state_r == S_DECAY, count_r != '0, "decay with zero count")
  `DWS_ASSERT_IMP(a_inc_in_table, state_r == S_HWR,
                  32'(sum_r) < dws_pkg::TIME_BINS, "bin out of table")
  `DWS_ASSERT_IMP(a_decay_write_owner, p2_valid_r, state_r == S_DECAY,
                  "decay write outside sweep")
  `DWS_ASSERT_IMP(a_div_done_in_div, div_done, state_r == S_DIV, "divide finished out of turn")
  `DWS_ASSERT_NEXT(a_report_counts, in_acc && is_report && count_r != '1,
                   count_r == $past(count_r) + 1'b1, "report not counted")

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int PROD_W         = dws_pkg::BIN_W + dws_pkg::W_W;

  typedef struct packed {
    logic [dws_pkg::BIN_W-1:0]   bin_value;
    logic [dws_pkg::COUNT_W-1:0] reports_seen;
  } bin_reading_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [dws_pkg::UW_W-1:0]     cfg_wr_data;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_operation;
  logic [dws_pkg::FT_W-1:0]     in_frame_time_ms;
  logic [dws_pkg::IDX_W-1:0]    in_bin_index;
  logic                         out_valid;
  logic                         out_ready;
  logic [dws_pkg::BIN_W-1:0]    out_bin_value;
  logic [dws_pkg::COUNT_W-1:0]  out_reports_seen;

  logic [dws_pkg::SUM_W-1:0]    window_sum [dws_pkg::RING_DEPTH];
  logic [dws_pkg::BIN_W-1:0]    hist_bin [dws_pkg::TIME_BINS];
  logic [dws_pkg::COUNT_W-1:0]  report_total;
  logic [dws_pkg::UW_W-1:0]     weight_floor;

  bin_reading_t        expected_readings [$];
  bin_reading_t        head_reading;
  int                  mismatch_count = 0;
  int                  quiet_cycles = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  hold_cycles = 0;

  always #2 clk = ~clk;

  decaying_window_sum_histogram_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_frame_time_ms (in_frame_time_ms),
    .in_bin_index     (in_bin_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bin_value    (out_bin_value),
    .out_reports_seen (out_reports_seen)
  );

  function automatic void reset_histogram();
    for (int i = 0; i < dws_pkg::RING_DEPTH; i++) begin
      window_sum[i] = dws_pkg::SUM_W'(dws_pkg::DEFAULT_FRAME_MS * (i + 1));
    end
    for (int i = 0; i < dws_pkg::TIME_BINS; i++) begin
      hist_bin[i] = '0;
    end
    report_total = '0;
    weight_floor = dws_pkg::UW_RESET;
  endfunction

  function automatic bin_reading_t process_item(input dws_pkg::op_t op,
                                                input logic [dws_pkg::FT_W-1:0] ft,
                                                input logic [dws_pkg::IDX_W-1:0] idx);
    logic [dws_pkg::SUM_W:0]      grown;
    logic [dws_pkg::W_W-1:0]      w;
    logic [dws_pkg::W_W-1:0]      keep;
    logic [dws_pkg::BIN_W:0]      bumped;
    logic [PROD_W-1:0]            scaled;
    logic [dws_pkg::HIST_AW-1:0]  slot;
    bin_reading_t                 r;
    r = '0;
    if (op == dws_pkg::OP_REPORT) begin
      if (report_total != '1) report_total++;
      for (int i = dws_pkg::FRAME_DEPTH; i >= 1; i--) begin
        grown = {1'b0, window_sum[i-1]} + (dws_pkg::SUM_W + 1)'(ft);
        window_sum[i] = (grown > {1'b0, dws_pkg::SUM_MAX}) ? dws_pkg::SUM_MAX
                                                           : grown[dws_pkg::SUM_W-1:0];
      end
      window_sum[0] = dws_pkg::SUM_W'(ft);
      w = dws_pkg::W_W'(dws_pkg::ONE_Q16 / report_total);
      if ({1'b0, weight_floor} > w) w = {1'b0, weight_floor};
      keep = dws_pkg::ONE_Q16 - w;
      for (int i = 0; i < dws_pkg::TIME_BINS; i++) begin
        scaled = PROD_W'(hist_bin[i]) * PROD_W'(keep);
        hist_bin[i] = scaled[dws_pkg::BIN_W+dws_pkg::FRAC_W-1:dws_pkg::FRAC_W];
      end
      for (int i = 0; i < dws_pkg::RING_DEPTH; i++) begin
        if (window_sum[i] >= dws_pkg::TIME_BINS) break;
        slot = window_sum[i][dws_pkg::HIST_AW-1:0];
        bumped = {1'b0, hist_bin[slot]} + (dws_pkg::BIN_W + 1)'(w);
        hist_bin[slot] = (bumped > {1'b0, dws_pkg::BIN_MAX}) ? dws_pkg::BIN_MAX
                                                             : bumped[dws_pkg::BIN_W-1:0];
      end
    end else if (32'(idx) < dws_pkg::TIME_BINS) begin
      r.bin_value = hist_bin[idx];
    end
    r.reports_seen = report_total;
    return r;
  endfunction

  function automatic logic [dws_pkg::IDX_W-1:0] pick_bin();
    int k;
    k = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, dws_pkg::FRAME_DEPTH);
    if ($urandom_range(0, 1) && window_sum[k] < dws_pkg::TIME_BINS) begin
      return window_sum[k][dws_pkg::IDX_W-1:0];
    end
    return dws_pkg::IDX_W'($urandom_range(0, dws_pkg::TIME_BINS - 1));
  endfunction

  task automatic send_item(input dws_pkg::op_t op, input logic [dws_pkg::FT_W-1:0] ft,
                           input logic [dws_pkg::IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_frame_time_ms <= ft;
    in_bin_index     <= idx;
    do @(posedge clk); while (!in_ready);
    expected_readings.push_back(process_item(op, ft, idx));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_weight_floor(input logic [dws_pkg::UW_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    weight_floor = value;
    @(posedge clk);
  endtask

  task automatic send_random_item();
    logic [dws_pkg::FT_W-1:0]  ft;
    logic [dws_pkg::IDX_W-1:0] idx;
    int                        pick;
    pick = $urandom_range(0, 99);
    idx  = pick_bin();
    ft   = dws_pkg::FT_W'($urandom_range(0, 1023));
    if (pick < 45) begin
      case ($urandom_range(0, 4))
        0, 1: ft = dws_pkg::FT_W'($urandom_range(0, 15));
        2: ft = dws_pkg::FT_W'($urandom_range(990, 1023));
        default: ;
      endcase
      send_item(dws_pkg::OP_REPORT, ft, idx);
    end else begin
      send_item(dws_pkg::OP_READ, ft, idx);
    end
  endtask

  task automatic test_reads_after_reset();
    send_item(dws_pkg::OP_READ, '0, '0);
    send_item(dws_pkg::OP_READ, dws_pkg::FT_W'(1023), dws_pkg::IDX_W'(4095));
    send_item(dws_pkg::OP_READ, '0, dws_pkg::IDX_W'(8));
    wait_idle();
  endtask

  task automatic test_report_extremes();
    send_item(dws_pkg::OP_REPORT, '0, dws_pkg::IDX_W'(4095));
    send_item(dws_pkg::OP_READ, '0, '0);
    send_item(dws_pkg::OP_READ, '0, dws_pkg::IDX_W'(8));
    send_item(dws_pkg::OP_READ, '0, dws_pkg::IDX_W'(16));
    send_item(dws_pkg::OP_REPORT, dws_pkg::FT_W'(1023), '0);
    send_item(dws_pkg::OP_REPORT, dws_pkg::FT_W'(1000), '0);
    send_item(dws_pkg::OP_REPORT, dws_pkg::FT_W'(512), '0);
    send_item(dws_pkg::OP_READ, '0, pick_bin());
    send_item(dws_pkg::OP_READ, '0, pick_bin());
    wait_idle();
  endtask

  task automatic test_bin_saturation();
    write_weight_floor(16'hFFFF);
    repeat (6) send_item(dws_pkg::OP_REPORT, '0, '0);
    send_item(dws_pkg::OP_READ, '0, '0);
    send_item(dws_pkg::OP_READ, '0, pick_bin());
    wait_idle();
    write_weight_floor(16'h0000);
    send_item(dws_pkg::OP_REPORT, dws_pkg::FT_W'(5), '0);
    send_item(dws_pkg::OP_READ, '0, dws_pkg::IDX_W'(5));
    wait_idle();
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input logic [dws_pkg::UW_W-1:0] floor_value,
                                   input int count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    write_weight_floor(floor_value);
    repeat (count) send_random_item();
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 400;
    repeat (12) begin
      send_item(dws_pkg::OP_READ, dws_pkg::FT_W'($urandom_range(0, 1023)), pick_bin());
    end
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $error("result with no pending item: bin_value %0d reports_seen %0d",
               out_bin_value, out_reports_seen);
        mismatch_count++;
      end else begin
        head_reading = expected_readings.pop_front();
        if (out_bin_value !== head_reading.bin_value) begin
          $error("bin_value: expected %0d, actual %0d", head_reading.bin_value, out_bin_value);
          mismatch_count++;
        end
        if (out_reports_seen !== head_reading.reports_seen) begin
          $error("reports_seen: expected %0d, actual %0d",
                 head_reading.reports_seen, out_reports_seen);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_valid         <= 1'b0;
    in_operation     <= dws_pkg::OP_REPORT;
    in_frame_time_ms <= '0;
    in_bin_index     <= '0;
    out_ready        <= 1'b0;
    reset_histogram();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reads_after_reset();
    test_report_extremes();
    test_bin_saturation();
    test_random_phase(0, 0, dws_pkg::UW_RESET, 21);
    test_random_phase(75, 0, 16'h0000, 21);
    test_random_phase(0, 75, dws_pkg::UW_W'($urandom_range(0, 65535)), 21);
    test_random_phase(7, 7, 16'hFFFF, 21);
    test_backpressure();

    wait_idle();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
